FILE: rtl/core/bks_pkg.sv
// Package for the bottom-k sketch core: item types, widths and register codes.
// No dependencies; imported by bottom_k_sketch_core.
`timescale 1ns / 1ps

package bks_pkg;

  // Field and datapath widths, emit limit and divider step count
  localparam int VAL_W     = 31;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 6;
  localparam int SIG_W     = 6;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int MAX_EMIT  = 32;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int DCNT_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Operation codes of an input item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_SIZE = 2'd3;

  // Configuration reset values
  localparam logic [VAL_W-1:0] COEF_A_RST   = 31'd1;
  localparam logic [VAL_W-1:0] COEF_B_RST   = 31'd0;
  localparam logic [VAL_W-1:0] MODULUS_RST  = 31'h7FFF_FFFF;
  localparam logic [SIG_W-1:0] SIG_SIZE_RST = 6'd20;

  // Input item
  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] element;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             last;
    logic             empty_res;
  } out_item_t;

endpackage

FILE: rtl/core/bottom_k_sketch_core.sv
// Bottom-k MinHash sketch core: permutation hash, sorted store and emitter.
// Depends on bks_pkg for item types, widths and register codes.
// Insert: accept, multiply, add, 31 two-bit remainder steps and slot choice; a store that
//   holds entries adds shift steps, and a full store first checks its largest entry.
// Finish: emits kept values in order, each held while out_stall is high, or one empty result.
// One item in work at a time, in_stall high until done; synchronous reset restores defaults.
`timescale 1ns / 1ps

module bottom_k_sketch_core #(
  parameter int SKETCH_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bks_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bks_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [bks_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bks_pkg::VAL_W-1:0]          cfg_wdata
);
  import bks_pkg::*;

  localparam int ADDR_W = (SKETCH_DEPTH > 1) ? $clog2(SKETCH_DEPTH) : 1;
  localparam int CAP    = (SKETCH_DEPTH < MAX_EMIT) ? SKETCH_DEPTH : MAX_EMIT;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_DIV, S_PREP, S_FULL, S_SHIFT, S_WRV, S_EMIT_LD, S_EMIT_WAIT
  } state_t;

  // Configuration registers
  logic [VAL_W-1:0] coef_a_r, coef_b_r, modulus_r;
  logic [SIG_W-1:0] sig_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r   <= COEF_A_RST;
      coef_b_r   <= COEF_B_RST;
      modulus_r  <= MODULUS_RST;
      sig_size_r <= SIG_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_A:   coef_a_r   <= cfg_wdata;
        CFG_COEF_B:   coef_b_r   <= cfg_wdata;
        CFG_MODULUS:  modulus_r  <= cfg_wdata;
        CFG_SIG_SIZE: sig_size_r <= cfg_wdata[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  state_t              state_r, state_nxt;
  logic [VAL_W-1:0]    x_r, x_nxt;
  logic [PROD_W-1:0]   t_r, t_nxt;
  logic [VAL_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0]    kept_count_r, kept_count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    emit_n_r, emit_n_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Store ports
  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [VAL_W-1:0]    wr_data, rd_q;
  logic [VAL_W-1:0]    mem [SKETCH_DEPTH];

  // Effective sketch size and current fill
  logic [CNT_W-1:0]    eff_k, n_cur;
  logic [CNT_W-1:0]    idx_m1;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W:0]      m_eff;
  logic [VAL_W:0]      s1, s2, r1, r2;

  always_comb begin
    eff_k = (sig_size_r == '0) ? CNT_W'(1) : sig_size_r;
    if (eff_k > CAP_C) begin
      eff_k = CAP_C;
    end
    n_cur = (kept_count_r > eff_k) ? eff_k : kept_count_r;
  end

  assign idx_m1 = idx_r - CNT_W'(1);

  // Multiplier; its product is registered before the add
  assign prod = coef_a_r * x_r;

  // A zero modulus acts as 2^31, which keeps the low 31 bits
  assign m_eff = (modulus_r == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, modulus_r};

  // Remainder unit: two restoring compare-and-subtract steps a cycle
  always_comb begin
    s1 = {rem_r, t_r[PROD_W-1]};
    r1 = (s1 >= m_eff) ? (s1 - m_eff) : s1;
    s2 = {r1[VAL_W-1:0], t_r[PROD_W-2]};
    r2 = (s2 >= m_eff) ? (s2 - m_eff) : s2;
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    t_nxt          = t_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    kept_count_nxt = kept_count_r;
    idx_nxt        = idx_r;
    emit_n_nxt     = emit_n_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rem_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_INSERT) begin
            x_nxt     = in_data.element;
            state_nxt = S_MUL;
          end else begin
            kept_count_nxt = '0;
            if (n_cur == '0) begin
              out_data_nxt.value     = '0;
              out_data_nxt.position  = '0;
              out_data_nxt.last      = 1'b1;
              out_data_nxt.empty_res = 1'b1;
              out_valid_nxt          = 1'b1;
              state_nxt              = S_EMIT_WAIT;
            end else begin
              emit_n_nxt = n_cur;
              idx_nxt    = '0;
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_nxt  = S_EMIT_LD;
            end
          end
        end
      end
      S_MUL: begin
        t_nxt     = prod;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        t_nxt     = t_r + PROD_W'(coef_b_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = r2[VAL_W-1:0];
        t_nxt    = t_r << 2;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_PREP;
        end
      end
      // Choose the start slot; a full sketch first checks its largest entry
      S_PREP: begin
        if (n_cur < eff_k) begin
          kept_count_nxt = n_cur + CNT_W'(1);
          idx_nxt        = n_cur;
          if (n_cur == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            state_nxt = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ADDR_W'(n_cur - CNT_W'(1));
            state_nxt = S_SHIFT;
          end
        end else begin
          kept_count_nxt = eff_k;
          idx_nxt        = eff_k - CNT_W'(1);
          rd_en          = 1'b1;
          rd_addr        = ADDR_W'(eff_k - CNT_W'(1));
          state_nxt      = S_FULL;
        end
      end
      S_FULL: begin
        if (rd_q <= rem_r) begin
          state_nxt = S_IDLE;
        end else if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ADDR_W'(idx_m1);
          state_nxt = S_SHIFT;
        end
      end
      // Move larger entries up one slot until the new value fits
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(idx_r);
        if (rd_q > rem_r) begin
          wr_data = rd_q;
          idx_nxt = idx_m1;
          if (idx_m1 == '0) begin
            state_nxt = S_WRV;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(idx_m1 - CNT_W'(1));
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WRV: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        state_nxt = S_IDLE;
      end
      S_EMIT_LD: begin
        out_data_nxt.value     = rd_q;
        out_data_nxt.position  = idx_r[POS_W-1:0];
        out_data_nxt.last      = (idx_r + CNT_W'(1) == emit_n_r);
        out_data_nxt.empty_res = 1'b0;
        out_valid_nxt          = 1'b1;
        state_nxt              = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            rd_en     = 1'b1;
            rd_addr   = ADDR_W'(idx_r + CNT_W'(1));
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kept_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kept_count_r <= kept_count_nxt;
      out_valid_r  <= out_valid_nxt;
      x_r          <= x_nxt;
      t_r          <= t_nxt;
      rem_r        <= rem_nxt;
      dcnt_r       <= dcnt_nxt;
      idx_r        <= idx_nxt;
      emit_n_r     <= emit_n_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  // Sorted store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    kept_count_r <= CAP_C)
    else $error("kept count exceeds capacity");

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_EMIT_WAIT)
    else $error("result shown outside the emit wait state");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> {1'b0, rem_r} < m_eff)
    else $error("partial remainder not below modulus");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.empty_res) |-> out_data_r.last)
    else $error("empty result not marked last");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD && idx_r != '0) |-> $past(out_data_r.value) <= rd_q)
    else $error("sketch emitted out of order");

endmodule
